FILE: rtl/second_order_iir_filter_assert.svh
// assertion macros for the second order iir filter
`ifndef SECOND_ORDER_IIR_FILTER_ASSERT_SVH
`define SECOND_ORDER_IIR_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

`define SOIIR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("soiir assertion failed");

`define SOIIR_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("soiir assertion failed");

`else

`define SOIIR_ASSERT(label, prop)
`define SOIIR_ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: rtl/soiir_pkg.sv
package soiir_pkg;

	localparam int COEF_BITS     = 19;
	localparam int OUT_BITS      = 16;
	localparam int CODE_BITS     = 12;
	localparam int FRAME_BITS    = 14;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic [1:0] {
		REG_GAIN_ONE   = 2'd0,
		REG_GAIN_TWO   = 2'd1,
		REG_INPUT_GAIN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] gain_one;
		logic signed [COEF_BITS-1:0] gain_two;
		logic signed [COEF_BITS-1:0] input_gain;
	} coef_set_t;

	localparam logic signed [COEF_BITS-1:0] GAIN_ONE_RST   = 19'sd127181;
	localparam logic signed [COEF_BITS-1:0] GAIN_TWO_RST   = 19'sd64238;
	localparam logic signed [COEF_BITS-1:0] INPUT_GAIN_RST = 19'sd649;

	localparam logic signed [OUT_BITS-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [OUT_BITS-1:0] OUT_MIN = 16'sh8000;

	localparam logic [FRAME_BITS-1:0] DAC_CTRL = 14'h3000;

endpackage

FILE: rtl/soiir_datapath.sv
module soiir_datapath #(
	parameter int SAMPLE_BITS    = 10,
	parameter int COEF_FRAC_BITS = 16
) (
	input  soiir_pkg::coef_set_t                       coefs,
	input  logic                  [SAMPLE_BITS-1:0]    s_last,
	input  logic                  [SAMPLE_BITS-1:0]    s_before,
	input  logic signed [soiir_pkg::OUT_BITS-1:0]      y_last,
	input  logic signed [soiir_pkg::OUT_BITS-1:0]      y_before,
	output logic signed [soiir_pkg::OUT_BITS-1:0]      y_new
);

	localparam int CB     = soiir_pkg::COEF_BITS;
	localparam int OB     = soiir_pkg::OUT_BITS;
	localparam int PROD_W = CB + OB;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PDIF_W = CB + DIFF_W;
	localparam int BASE_W = ((PROD_W > PDIF_W) ? PROD_W : PDIF_W) + 2;
	localparam int ACC_W  = (BASE_W > COEF_FRAC_BITS + OB + 1) ? BASE_W
	                        : COEF_FRAC_BITS + OB + 1;
	localparam int QUO_W  = ACC_W - COEF_FRAC_BITS;

	logic signed [CB-1:0]     g1;
	logic signed [CB-1:0]     g2;
	logic signed [CB-1:0]     gi;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] p1;
	logic signed [PROD_W-1:0] p2;
	logic signed [PDIF_W-1:0] p3;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_b;
	logic signed [QUO_W-1:0]  quo;
	logic [QUO_W-OB:0]        quo_hi;
	logic                     ovf;

	assign g1 = coefs.gain_one;
	assign g2 = coefs.gain_two;
	assign gi = coefs.input_gain;

	assign diff = $signed({1'b0, s_last}) - $signed({1'b0, s_before});

	assign p1 = PROD_W'(g1) * PROD_W'(y_last);
	assign p2 = PROD_W'(g2) * PROD_W'(y_before);
	assign p3 = PDIF_W'(gi) * PDIF_W'(diff);

	assign acc = ACC_W'(p1) - ACC_W'(p2) + ACC_W'(p3);

	// bias negative sums so the shift truncates toward zero
	assign acc_b = acc + $signed({{QUO_W{1'b0}}, {COEF_FRAC_BITS{acc[ACC_W-1]}}});
	assign quo   = acc_b[ACC_W-1:COEF_FRAC_BITS];

	assign quo_hi = quo[QUO_W-1:OB-1];
	assign ovf    = !((&quo_hi) || !(|quo_hi));

	always_comb begin
		if (ovf) begin
			y_new = quo[QUO_W-1] ? soiir_pkg::OUT_MIN : soiir_pkg::OUT_MAX;
		end else begin
			y_new = quo[OB-1:0];
		end
	end

endmodule

FILE: rtl/second_order_iir_filter.sv
// second order iir resonator on a converter sample stream
//
// input channel: in_valid / in_ready with one unsigned sample per item.
// output channel: out_valid / out_ready with filtered (signed 16 bits),
// dac_code (low 12 bits of filtered) and dac_frame (control bits 11 then
// the code). each input item gives exactly one output item.
// the new output depends on the two previous samples and the two previous
// outputs; the sample of an item only enters the result from the next item on.
// out_valid is registered and rises in the cycle after an input accept.
// throughput: one item per cycle while the receiver does not stall; the
// three products, their sum, the truncating shift and the saturation are
// combinational logic between the filter state registers and output register.
// if the receiver stalls, the output register holds its item and in_ready
// drops until that item is taken; in_ready is high in the same cycle that
// the held item is taken.
// reset clears the sample and output history, the output valid flag and
// loads the default coefficients. coefficients are written over the apb port
// at byte addresses 0, 4 and 8 and read back sign extended.
`include "second_order_iir_filter_assert.svh"

module second_order_iir_filter #(
	parameter int SAMPLE_BITS    = 10,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [soiir_pkg::APB_ADDR_BITS-1:0]       paddr,
	input  logic [soiir_pkg::APB_DATA_BITS-1:0]       pwdata,
	output logic [soiir_pkg::APB_DATA_BITS-1:0]       prdata,
	output logic                                      pready,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [SAMPLE_BITS-1:0]                    sample,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [soiir_pkg::OUT_BITS-1:0]     filtered,
	output logic [soiir_pkg::CODE_BITS-1:0]           dac_code,
	output logic [soiir_pkg::FRAME_BITS-1:0]          dac_frame
);

	localparam int CB = soiir_pkg::COEF_BITS;
	localparam int DB = soiir_pkg::APB_DATA_BITS;

	soiir_pkg::coef_set_t                 coefs_q;
	soiir_pkg::reg_idx_t                  reg_idx;
	logic                                 cfg_wr;
	logic                                 in_fire;
	logic [SAMPLE_BITS-1:0]               sample_last_q;
	logic [SAMPLE_BITS-1:0]               sample_before_q;
	logic signed [soiir_pkg::OUT_BITS-1:0] output_last_q;
	logic signed [soiir_pkg::OUT_BITS-1:0] output_before_q;
	logic signed [soiir_pkg::OUT_BITS-1:0] y_new;
	logic signed [soiir_pkg::OUT_BITS-1:0] result_q;
	logic                                 out_valid_q;

	assign pready  = 1'b1;
	assign reg_idx = soiir_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.gain_one   <= soiir_pkg::GAIN_ONE_RST;
			coefs_q.gain_two   <= soiir_pkg::GAIN_TWO_RST;
			coefs_q.input_gain <= soiir_pkg::INPUT_GAIN_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				soiir_pkg::REG_GAIN_ONE:   coefs_q.gain_one   <= pwdata[CB-1:0];
				soiir_pkg::REG_GAIN_TWO:   coefs_q.gain_two   <= pwdata[CB-1:0];
				soiir_pkg::REG_INPUT_GAIN: coefs_q.input_gain <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			soiir_pkg::REG_GAIN_ONE:
				prdata = {{(DB-CB){coefs_q.gain_one[CB-1]}}, coefs_q.gain_one};
			soiir_pkg::REG_GAIN_TWO:
				prdata = {{(DB-CB){coefs_q.gain_two[CB-1]}}, coefs_q.gain_two};
			soiir_pkg::REG_INPUT_GAIN:
				prdata = {{(DB-CB){coefs_q.input_gain[CB-1]}}, coefs_q.input_gain};
			default:
				prdata = '0;
		endcase
	end

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	soiir_datapath #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.coefs    (coefs_q),
		.s_last   (sample_last_q),
		.s_before (sample_before_q),
		.y_last   (output_last_q),
		.y_before (output_before_q),
		.y_new    (y_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_last_q   <= '0;
			sample_before_q <= '0;
			output_last_q   <= '0;
			output_before_q <= '0;
		end else if (in_fire) begin
			sample_last_q   <= sample;
			sample_before_q <= sample_last_q;
			output_last_q   <= y_new;
			output_before_q <= output_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			result_q <= y_new;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = result_q;
	assign dac_code  = result_q[soiir_pkg::CODE_BITS-1:0];
	assign dac_frame = soiir_pkg::DAC_CTRL
	                   | soiir_pkg::FRAME_BITS'(result_q[soiir_pkg::CODE_BITS-1:0]);

	`SOIIR_ASSERT(a_fire_gives_item, in_fire |=> out_valid)
	`SOIIR_ASSERT(a_feedback_matches_out, in_fire |=> (output_last_q == filtered))
	`SOIIR_ASSERT(a_sample_history, in_fire |=> (sample_last_q == $past(sample)))
	`SOIIR_ASSERT_ALWAYS(a_reset_no_item, !arst_n |-> !out_valid)

endmodule
